>>> hw/rtl/bzpg_pkg.sv
// Shared constants for the cubic Bezier point generator.
package bzpg_pkg;
	localparam int SEG_BITS = 6;
	localparam logic [SEG_BITS-1:0] SEG_RESET = 6'd10;
	localparam int MAX_SEGMENTS_DEF = 63;
	localparam int COORD_BITS_DEF = 16;
	localparam int SQ_BITS = 2 * SEG_BITS;
	localparam int N3_BITS = 3 * SEG_BITS;
	localparam int W_BITS = N3_BITS + 2;
endpackage

>>> hw/rtl/bzpg_fifo.sv
// Two-entry queue between the front and back sections.
module bzpg_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign full = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end
endmodule

>>> hw/rtl/bzpg_front.sv
// Front section: accept curve items, clamp the segment count, queue them.
module bzpg_front #(
	parameter int COORD_BITS = bzpg_pkg::COORD_BITS_DEF,
	parameter int MAX_SEGMENTS = bzpg_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_stall,
	input  logic [12*COORD_BITS-1:0]                   in_pts,
	input  logic [bzpg_pkg::SEG_BITS-1:0]              segments,
	input  logic                                       q_pop,
	output logic                                       q_not_empty,
	output logic [12*COORD_BITS+bzpg_pkg::SEG_BITS-1:0] q_data
);
	localparam int QW = 12 * COORD_BITS + bzpg_pkg::SEG_BITS;
	localparam logic [bzpg_pkg::SEG_BITS-1:0] NMAX = bzpg_pkg::SEG_BITS'(MAX_SEGMENTS);

	logic                          full;
	logic                          push;
	logic [bzpg_pkg::SEG_BITS-1:0] n_eff;

	always_comb begin
		priority if (segments == '0) begin
			n_eff = bzpg_pkg::SEG_BITS'(1);
		end else if (segments > NMAX) begin
			n_eff = NMAX;
		end else begin
			n_eff = segments;
		end
	end

	assign in_stall = full;
	assign push = in_valid && !full;

	bzpg_fifo #(.WIDTH(QW)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({n_eff, in_pts}),
		.full(full),
		.pop(q_pop),
		.not_empty(q_not_empty),
		.pop_data(q_data)
	);
endmodule

>>> hw/rtl/bzpg_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module bzpg_div #(
	parameter int NUM_BITS = 48,
	parameter int DEN_BITS = 19,
	parameter int Q_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic                done,
	output logic [Q_BITS-1:0]   quo
);
	localparam int IDX_BITS = $clog2(Q_BITS);

	logic [NUM_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [Q_BITS-1:0]   quo_q;
	logic [IDX_BITS-1:0] idx_q;
	logic                busy_q;
	logic                done_q;
	logic [NUM_BITS-1:0] dsh;

	assign dsh = NUM_BITS'(den_q) << idx_q;
	assign done = done_q;
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q <= '0;
		end else begin
			done_q <= !start && busy_q && (idx_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				idx_q <= IDX_BITS'(Q_BITS - 1);
			end else if (busy_q) begin
				if (idx_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q - IDX_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= dsh) begin
				rem_q <= rem_q - dsh;
				quo_q[idx_q] <= 1'b1;
			end
		end
	end
endmodule

>>> hw/rtl/bzpg_back.sv
// Back section: evaluate each curve point and drive the output register.
module bzpg_back #(
	parameter int COORD_BITS = bzpg_pkg::COORD_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       q_not_empty,
	input  logic [12*COORD_BITS+bzpg_pkg::SEG_BITS-1:0] q_data,
	output logic                                       q_pop,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output logic signed [COORD_BITS-1:0]               pt_x,
	output logic signed [COORD_BITS-1:0]               pt_y,
	output logic signed [COORD_BITS-1:0]               pt_z,
	output logic [bzpg_pkg::SEG_BITS-1:0]              point_index,
	output logic                                       last_point
);
	localparam int SB = bzpg_pkg::SEG_BITS;
	localparam int WB = bzpg_pkg::W_BITS;
	localparam int QB = bzpg_pkg::SQ_BITS;
	localparam int CB = bzpg_pkg::N3_BITS;
	localparam int PROD_BITS = WB + 1 + COORD_BITS;
	localparam int SUM_BITS = PROD_BITS + 2;
	localparam int NUM_BITS = SUM_BITS + 2;
	localparam int DEN_BITS = bzpg_pkg::N3_BITS + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_SQ, S_CUBE, S_MUL, S_SUM, S_DIV, S_OUT
	} state_t;

	state_t state_q;
	logic [SB-1:0] n_q;
	logic [SB-1:0] k_q;
	logic signed [COORD_BITS-1:0] p_q [4][3];
	logic [bzpg_pkg::SQ_BITS-1:0] aa_q, kk_q, nn_q;
	logic [SB-1:0] a_q;
	logic [WB-1:0] w_q [4];
	logic [bzpg_pkg::N3_BITS-1:0] n3_q;
	logic signed [PROD_BITS-1:0] prod_q [4][3];
	logic [NUM_BITS-1:0] num_q [3];
	logic [DEN_BITS-1:0] den_q;
	logic [2:0] neg_q;
	logic div_start_q;
	logic [2:0] div_done;
	logic [COORD_BITS-1:0] quo [3];
	logic signed [COORD_BITS-1:0] res [3];
	logic out_valid_q;
	logic signed [COORD_BITS-1:0] ox_q, oy_q, oz_q;
	logic [SB-1:0] oidx_q;
	logic olast_q;
	logic [bzpg_pkg::N3_BITS-1:0] aak;
	logic [bzpg_pkg::N3_BITS-1:0] akk;
	logic [SUM_BITS-1:0] sum [3];
	logic can_load;

	assign q_pop = (state_q == S_IDLE) && q_not_empty;
	assign aak = CB'(aa_q) * CB'(k_q);
	assign akk = CB'(kk_q) * CB'(a_q);
	assign can_load = !out_valid_q || !out_stall;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = $signed(prod_q[0][c]) + $signed(prod_q[1][c])
				+ $signed(prod_q[2][c]) + $signed(prod_q[3][c]);
			if (!neg_q[c] && quo[c][COORD_BITS-1]) begin
				res[c] = {1'b0, {(COORD_BITS-1){1'b1}}};
			end else if (neg_q[c]) begin
				res[c] = -$signed(quo[c]);
			end else begin
				res[c] = $signed(quo[c]);
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_div
		bzpg_div #(
			.NUM_BITS(NUM_BITS),
			.DEN_BITS(DEN_BITS),
			.Q_BITS(COORD_BITS)
		) u_div (
			.clk(clk),
			.arst_n(arst_n),
			.start(div_start_q),
			.num(num_q[c]),
			.den(den_q),
			.done(div_done[c]),
			.quo(quo[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
			k_q <= '0;
			n_q <= '0;
		end else begin
			div_start_q <= (state_q == S_SUM);
			out_valid_q <= ((state_q == S_OUT) && can_load) || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (q_not_empty) begin
						n_q <= q_data[12*COORD_BITS +: SB];
						k_q <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: state_q <= S_CUBE;
				S_CUBE: state_q <= S_MUL;
				S_MUL: state_q <= S_SUM;
				S_SUM: state_q <= S_DIV;
				S_DIV: begin
					if (div_done[0]) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (can_load) begin
						if (k_q == n_q) begin
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + SB'(1);
							state_q <= S_SQ;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_not_empty) begin
			for (int i = 0; i < 4; i++) begin
				for (int c = 0; c < 3; c++) begin
					p_q[i][c] <= $signed(q_data[(i*3+c)*COORD_BITS +: COORD_BITS]);
				end
			end
		end
		if (state_q == S_SQ) begin
			a_q <= n_q - k_q;
			aa_q <= QB'(n_q - k_q) * QB'(n_q - k_q);
			kk_q <= QB'(k_q) * QB'(k_q);
			nn_q <= QB'(n_q) * QB'(n_q);
		end
		if (state_q == S_CUBE) begin
			w_q[0] <= WB'(CB'(aa_q) * CB'(a_q));
			w_q[1] <= WB'({aak, 1'b0}) + WB'(aak);
			w_q[2] <= WB'({akk, 1'b0}) + WB'(akk);
			w_q[3] <= WB'(CB'(kk_q) * CB'(k_q));
			n3_q <= CB'(nn_q) * CB'(n_q);
		end
		if (state_q == S_MUL) begin
			for (int i = 0; i < 4; i++) begin
				for (int c = 0; c < 3; c++) begin
					prod_q[i][c] <= $signed({1'b0, w_q[i]}) * p_q[i][c];
				end
			end
		end
		if (state_q == S_SUM) begin
			den_q <= {n3_q, 1'b0};
			for (int c = 0; c < 3; c++) begin
				neg_q[c] <= sum[c][SUM_BITS-1];
				num_q[c] <= {(sum[c][SUM_BITS-1] ? -sum[c] : sum[c]), 1'b0}
					+ NUM_BITS'(n3_q);
			end
		end
		if (state_q == S_OUT && can_load) begin
			ox_q <= res[0];
			oy_q <= res[1];
			oz_q <= res[2];
			oidx_q <= k_q;
			olast_q <= (k_q == n_q);
		end
	end

	assign out_valid = out_valid_q;
	assign pt_x = ox_q;
	assign pt_y = oy_q;
	assign pt_z = oz_q;
	assign point_index = oidx_q;
	assign last_point = olast_q;
endmodule

>>> hw/rtl/cubic_bezier_point_generator.sv
// Cubic Bezier point generator: top level.
// Usage:
//   Input channel (in_valid/in_stall) takes one item: four 3D control
//   points p0..p3, signed COORD_BITS each. An item is taken when in_valid
//   is high and in_stall is low. Two items can wait in the queue.
//   Output channel (out_valid/out_stall) emits n+1 points per item, k=0..n,
//   with point_index = k and last_point set on k = n. A point is taken
//   when out_valid is high and out_stall is low.
//   cfg_we/cfg_data write the segment count n (0 acts as 1, values above
//   MAX_SEGMENTS act as MAX_SEGMENTS); write only while idle.
// Sequence:
//   Each point steps through S_SQ, S_CUBE, S_MUL, S_SUM, S_DIV and S_OUT;
//   S_DIV waits on the bit-serial divider by 2*n^3. An item leaves the
//   queue only when the back section is idle, after the last point of the
//   previous item has been loaded into the output register.
// Reset: arst_n clears the queue and output; segments returns to 10.
// Stall: a held output point stays stable; the next point waits finished
//   in the divider, and the queue keeps taking items until full.
module cubic_bezier_point_generator #(
	parameter int MAX_SEGMENTS = bzpg_pkg::MAX_SEGMENTS_DEF,
	parameter int COORD_BITS = bzpg_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bzpg_pkg::SEG_BITS-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  p0_x,
	input  logic signed [COORD_BITS-1:0]  p0_y,
	input  logic signed [COORD_BITS-1:0]  p0_z,
	input  logic signed [COORD_BITS-1:0]  p1_x,
	input  logic signed [COORD_BITS-1:0]  p1_y,
	input  logic signed [COORD_BITS-1:0]  p1_z,
	input  logic signed [COORD_BITS-1:0]  p2_x,
	input  logic signed [COORD_BITS-1:0]  p2_y,
	input  logic signed [COORD_BITS-1:0]  p2_z,
	input  logic signed [COORD_BITS-1:0]  p3_x,
	input  logic signed [COORD_BITS-1:0]  p3_y,
	input  logic signed [COORD_BITS-1:0]  p3_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_BITS-1:0]  pt_x,
	output logic signed [COORD_BITS-1:0]  pt_y,
	output logic signed [COORD_BITS-1:0]  pt_z,
	output logic [bzpg_pkg::SEG_BITS-1:0] point_index,
	output logic                          last_point
);
	localparam int QW = 12 * COORD_BITS + bzpg_pkg::SEG_BITS;

	logic [bzpg_pkg::SEG_BITS-1:0] segments_q;
	logic                          q_pop;
	logic                          q_not_empty;
	logic [QW-1:0]                 q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segments_q <= bzpg_pkg::SEG_RESET;
		end else if (cfg_we) begin
			segments_q <= cfg_data;
		end
	end

	bzpg_front #(
		.COORD_BITS(COORD_BITS),
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_pts({p3_z, p3_y, p3_x, p2_z, p2_y, p2_x,
			p1_z, p1_y, p1_x, p0_z, p0_y, p0_x}),
		.segments(segments_q),
		.q_pop(q_pop),
		.q_not_empty(q_not_empty),
		.q_data(q_data)
	);

	bzpg_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_not_empty(q_not_empty),
		.q_data(q_data),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pt_x(pt_x),
		.pt_y(pt_y),
		.pt_z(pt_z),
		.point_index(point_index),
		.last_point(last_point)
	);
endmodule
